>>> src/longest_prefix_pattern_select_top_assert.svh
// Assertion helpers for the pattern select block.
// The including module must have clk and arst_n in scope.
`ifndef LONGEST_PREFIX_PATTERN_SELECT_TOP_ASSERT_SVH
`define LONGEST_PREFIX_PATTERN_SELECT_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/lpps_pkg.sv
package lpps_pkg;

	localparam int MAX_REF_LEN  = 4096;
	localparam int MAX_PATTERNS = 16;
	localparam int MAX_PAT_LEN  = 1024;

	// Field widths of the request.
	localparam int REQ_W    = 2;
	localparam int CHAR_W   = 8;
	localparam int OFFSET_W = 13;

	localparam int REF_AW    = $clog2(MAX_REF_LEN);
	localparam int REF_LEN_W = $clog2(MAX_REF_LEN + 1);
	localparam int PAT_IDX_W = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
	localparam int CNT_W     = $clog2(MAX_PATTERNS + 1);
	localparam int PAT_OFF_W = $clog2(MAX_PAT_LEN);
	localparam int PLEN_W    = $clog2(MAX_PAT_LEN + 1);
	localparam int PAT_AW    = PAT_IDX_W + PAT_OFF_W;
	localparam int PAT_DEPTH = MAX_PATTERNS * MAX_PAT_LEN;
	localparam int CMP_W     = (OFFSET_W > REF_LEN_W) ? OFFSET_W : REF_LEN_W;

	localparam logic [REQ_W-1:0] REQ_REF_APPEND = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PAT_APPEND = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY      = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR      = 2'd3;

endpackage

>>> src/longest_prefix_pattern_select_top.sv
// Appends and clears give no result.
// A query scans the patterns in turn and loads its result once the scan has passed the
// last pattern. Each pattern takes a setup step, followed by a run of character compares
// when its offset lies inside both the reference and the pattern.
// Each memory gives one character read per cycle; the next request follows the load.
// Reset empties the store at once; no clearing pass is needed.
`include "longest_prefix_pattern_select_top_assert.svh"

module longest_prefix_pattern_select_top
	import lpps_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [CHAR_W-1:0]   char_value,
	input  logic                last_of_string,
	input  logic [OFFSET_W-1:0] query_offset,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CNT_W-1:0]    best_pattern,
	output logic [PLEN_W-1:0]   match_length
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]           state_q;
	logic [REF_LEN_W-1:0] reflen_q;
	logic [CNT_W-1:0]     pat_count_q;
	logic                 pat_open_q;
	logic [PLEN_W-1:0]    plen_q [MAX_PATTERNS];

	logic [CNT_W-1:0]     idx_q;
	logic [OFFSET_W-1:0]  offset_q;
	logic [CMP_W-1:0]     pos_q;
	logic [CMP_W-1:0]     limit_q;
	logic [PLEN_W-1:0]    run_q;
	logic [CNT_W-1:0]     best_q;
	logic [PLEN_W-1:0]    best_len_q;

	logic                 out_valid_q;
	logic [CNT_W-1:0]     best_pattern_q;
	logic [PLEN_W-1:0]    match_length_q;

	logic                 in_accept;
	logic                 out_accept;
	logic                 out_load;

	logic [PAT_IDX_W-1:0] last_slot;
	logic [PAT_IDX_W-1:0] app_slot;
	logic [PAT_IDX_W-1:0] plen_idx;
	logic [PLEN_W-1:0]    plen_rd;
	logic [PLEN_W-1:0]    app_len;
	logic                 app_ok;
	logic                 wr_pat;
	logic                 ref_we;
	logic                 pat_we;

	logic [CMP_W-1:0]     limit_c;
	logic [CMP_W-1:0]     rd_pos;
	logic [CHAR_W-1:0]    ref_rdata;
	logic [CHAR_W-1:0]    pat_rdata;
	logic                 chars_eq;
	logic [PLEN_W-1:0]    run_inc;
	logic [PLEN_W-1:0]    fin_run;
	logic                 run_more;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign out_accept = out_valid_q && !out_stall;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign out_valid    = out_valid_q;
	assign best_pattern = best_pattern_q;
	assign match_length = match_length_q;

	// Slot bookkeeping for pattern appends. The length table has a single read
	// port, shared between appends (idle) and the query scan.
	assign last_slot = pat_count_q[PAT_IDX_W-1:0] - PAT_IDX_W'(1);
	assign app_slot  = pat_open_q ? last_slot : pat_count_q[PAT_IDX_W-1:0];
	assign plen_idx  = (state_q == ST_IDLE) ? last_slot : idx_q[PAT_IDX_W-1:0];
	assign plen_rd   = plen_q[plen_idx];
	assign app_len   = pat_open_q ? plen_rd : '0;
	assign app_ok    = pat_open_q || (pat_count_q < CNT_W'(MAX_PATTERNS));
	assign wr_pat    = app_ok && (app_len < PLEN_W'(MAX_PAT_LEN));

	assign ref_we = in_accept && (req_type == REQ_REF_APPEND)
		&& (reflen_q < REF_LEN_W'(MAX_REF_LEN));
	assign pat_we = in_accept && (req_type == REQ_PAT_APPEND) && wr_pat;

	assign limit_c = (CMP_W'(reflen_q) < CMP_W'(plen_rd)) ? CMP_W'(reflen_q) : CMP_W'(plen_rd);
	assign rd_pos  = (state_q == ST_SETUP) ? CMP_W'(offset_q) : pos_q;

	lpps_ram #(
		.DEPTH (MAX_REF_LEN),
		.WIDTH (CHAR_W)
	) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (reflen_q[REF_AW-1:0]),
		.wdata (char_value),
		.raddr (rd_pos[REF_AW-1:0]),
		.rdata (ref_rdata)
	);

	lpps_ram #(
		.DEPTH (PAT_DEPTH),
		.WIDTH (CHAR_W)
	) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr ({app_slot, app_len[PAT_OFF_W-1:0]}),
		.wdata (char_value),
		.raddr ({idx_q[PAT_IDX_W-1:0], rd_pos[PAT_OFF_W-1:0]}),
		.rdata (pat_rdata)
	);

	// The read data in the run state belongs to the position issued in the cycle before.
	assign chars_eq = (ref_rdata == pat_rdata);
	assign run_inc  = run_q + PLEN_W'(1);
	assign fin_run  = chars_eq ? run_inc : run_q;
	assign run_more = chars_eq && (pos_q < limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reflen_q    <= '0;
			pat_count_q <= '0;
			pat_open_q  <= 1'b0;
			for (int i = 0; i < MAX_PATTERNS; i++) begin
				plen_q[i] <= '0;
			end
		end else if (in_accept) begin
			unique case (req_type)
				REQ_REF_APPEND: begin
					if (reflen_q < REF_LEN_W'(MAX_REF_LEN)) begin
						reflen_q <= reflen_q + REF_LEN_W'(1);
					end
				end
				REQ_PAT_APPEND: begin
					if (app_ok) begin
						if (!pat_open_q) begin
							pat_count_q <= pat_count_q + CNT_W'(1);
						end
						plen_q[app_slot] <= wr_pat ? app_len + PLEN_W'(1) : app_len;
						pat_open_q       <= !last_of_string;
					end
				end
				REQ_QUERY: begin
				end
				REQ_CLEAR: begin
					reflen_q    <= '0;
					pat_count_q <= '0;
					pat_open_q  <= 1'b0;
					for (int i = 0; i < MAX_PATTERNS; i++) begin
						plen_q[i] <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && (req_type == REQ_QUERY)) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (idx_q == pat_count_q) begin
						state_q <= ST_DONE;
					end else if (CMP_W'(offset_q) < limit_c) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!run_more) begin
						state_q <= ST_SETUP;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				idx_q      <= '0;
				offset_q   <= query_offset;
				best_q     <= CNT_W'(1);
				best_len_q <= '0;
			end
			ST_SETUP: begin
				pos_q   <= CMP_W'(offset_q) + CMP_W'(1);
				limit_q <= limit_c;
				run_q   <= '0;
				if ((idx_q != pat_count_q) && (CMP_W'(offset_q) >= limit_c)) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			ST_RUN: begin
				if (run_more) begin
					pos_q <= pos_q + CMP_W'(1);
					run_q <= run_inc;
				end else begin
					if (fin_run > best_len_q) begin
						best_len_q <= fin_run;
						best_q     <= idx_q + CNT_W'(1);
					end
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_accept) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			best_pattern_q <= best_q;
			match_length_q <= best_len_q;
		end
	end

	`LPPS_ASSERT_NOW(a_scan_idx_bound, state_q != ST_IDLE, idx_q <= pat_count_q, "scan index beyond pattern count")
	`LPPS_ASSERT_NOW(a_run_pos_bound, state_q == ST_RUN, pos_q <= limit_q, "read position beyond comparison limit")
	`LPPS_ASSERT_NEXT(a_done_holds, (state_q == ST_DONE) && out_valid_q && out_stall, state_q == ST_DONE, "result dropped while output stalled")
	`LPPS_ASSERT_NOW(a_best_consistent, state_q == ST_SETUP, (best_len_q == '0) || ((best_q != '0) && (best_q <= idx_q)), "winner index inconsistent with scan")

endmodule

>>> src/lpps_ram.sv
module lpps_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
